// ===== rtl/clb_pkg.sv =====
// shared types, codes and defaults for the cursor list buffer
package clb_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_APPEND = 3'd1;
	localparam logic [2:0] KIND_REMOVE = 3'd2;
	localparam logic [2:0] KIND_START  = 3'd3;
	localparam logic [2:0] KIND_END    = 3'd4;
	localparam logic [2:0] KIND_PREV   = 3'd5;
	localparam logic [2:0] KIND_NEXT   = 3'd6;
	localparam logic [2:0] KIND_MOVE   = 3'd7;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_BADPOS = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_INS_RD,
		CMD_INS_WR,
		CMD_INS_PUT,
		CMD_APP,
		CMD_REM_RD,
		CMD_REM_CAP,
		CMD_REM_NXT,
		CMD_REM_WR,
		CMD_REM_END,
		CMD_RO_RD,
		CMD_RO_WR,
		CMD_CP_RD,
		CMD_CP_WR,
		CMD_FIN_OUT,
		CMD_RO_END
	} cmd_t;

	typedef struct packed {
		logic       in_reorder;
		logic [2:0] in_kind;
		logic       full;
		logic       empty;
		logic       short_list;
		logic       ins_more;
		logic       rem_more;
		logic       k_more;
	} dp_status_t;

endpackage

// ===== rtl/clb_ctrl.sv =====
// sequencer that steps the datapath through each operation
module clb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  clb_pkg::dp_status_t st,
	output clb_pkg::cmd_t       cmd
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_INS_LOOP = 14'b00000000000010,
		S_INS_WR   = 14'b00000000000100,
		S_APP_WR   = 14'b00000000001000,
		S_REM_RD   = 14'b00000000010000,
		S_REM_CAP  = 14'b00000000100000,
		S_REM_LOOP = 14'b00000001000000,
		S_REM_WR   = 14'b00000010000000,
		S_RO_LOOP  = 14'b00000100000000,
		S_RO_WR    = 14'b00001000000000,
		S_CP_LOOP  = 14'b00010000000000,
		S_CP_WR    = 14'b00100000000000,
		S_FIN_RD   = 14'b01000000000000,
		S_FIN_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load_out;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_out  = (state_q == S_FIN_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd     = clb_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = clb_pkg::CMD_ACCEPT;
					if (st.in_reorder) begin
						state_d = st.short_list ? S_FIN_RD : S_RO_LOOP;
					end else begin
						unique case (st.in_kind)
							clb_pkg::KIND_INSERT: state_d = st.full ? S_FIN_RD : S_INS_LOOP;
							clb_pkg::KIND_APPEND: state_d = st.full ? S_FIN_RD : S_APP_WR;
							clb_pkg::KIND_REMOVE: state_d = st.empty ? S_FIN_RD : S_REM_RD;
							default:              state_d = S_FIN_RD;
						endcase
					end
				end
			end
			S_INS_LOOP: begin
				if (st.ins_more) begin
					cmd     = clb_pkg::CMD_INS_RD;
					state_d = S_INS_WR;
				end else begin
					cmd     = clb_pkg::CMD_INS_PUT;
					state_d = S_FIN_RD;
				end
			end
			S_INS_WR: begin
				cmd     = clb_pkg::CMD_INS_WR;
				state_d = S_INS_LOOP;
			end
			S_APP_WR: begin
				cmd     = clb_pkg::CMD_APP;
				state_d = S_FIN_RD;
			end
			S_REM_RD: begin
				cmd     = clb_pkg::CMD_REM_RD;
				state_d = S_REM_CAP;
			end
			S_REM_CAP: begin
				cmd     = clb_pkg::CMD_REM_CAP;
				state_d = S_REM_LOOP;
			end
			S_REM_LOOP: begin
				if (st.rem_more) begin
					cmd     = clb_pkg::CMD_REM_NXT;
					state_d = S_REM_WR;
				end else begin
					cmd     = clb_pkg::CMD_REM_END;
					state_d = S_FIN_RD;
				end
			end
			S_REM_WR: begin
				cmd     = clb_pkg::CMD_REM_WR;
				state_d = S_REM_LOOP;
			end
			S_RO_LOOP: begin
				if (st.k_more) begin
					cmd     = clb_pkg::CMD_RO_RD;
					state_d = S_RO_WR;
				end else begin
					cmd     = clb_pkg::CMD_RO_END;
					state_d = S_CP_LOOP;
				end
			end
			S_RO_WR: begin
				cmd     = clb_pkg::CMD_RO_WR;
				state_d = S_RO_LOOP;
			end
			S_CP_LOOP: begin
				if (st.k_more) begin
					cmd     = clb_pkg::CMD_CP_RD;
					state_d = S_CP_WR;
				end else begin
					state_d = S_FIN_RD;
				end
			end
			S_CP_WR: begin
				cmd     = clb_pkg::CMD_CP_WR;
				state_d = S_CP_LOOP;
			end
			S_FIN_RD: begin
				state_d = S_FIN_OUT;
			end
			S_FIN_OUT: begin
				if (load_out) begin
					cmd     = clb_pkg::CMD_FIN_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/clb_dp.sv =====
// datapath: entry memory, scratch memory, length, cursor and result registers
module clb_dp #(
	parameter int CAPACITY = clb_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clb_pkg::cmd_t        cmd,
	output clb_pkg::dp_status_t  st,
	input  logic [2:0]           kind,
	input  logic                 do_reorder,
	input  logic signed [31:0]   new_value,
	input  logic [5:0]           target_position,
	output logic [1:0]           status,
	output logic signed [31:0]   removed_value,
	output logic signed [31:0]   cursor_value,
	output logic                 cursor_valid,
	output logic [6:0]           list_length,
	output logic [5:0]           cursor_position
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [31:0]   store_mem [CAPACITY];
	logic [31:0]   scratch_mem [CAPACITY];
	logic [31:0]   rd_q, srd_q;
	logic [CW-1:0] count_q, ptr_q;
	logic [IW-1:0] cur_q, lo_q, hi_q;
	logic [31:0]   val_q;
	logic [1:0]    status_q;
	logic [31:0]   removed_q;

	logic          full, empty;
	logic [IW-1:0] raddr, waddr, saddr;
	logic          we, swe;
	logic [31:0]   wdata;
	logic [CW-1:0] ptr_inc, ptr_dec, cnt_dec, cur_ext;
	logic [1:0]    acc_status;
	logic [CW-1:0] acc_ptr;

	assign full    = (count_q >= CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign ptr_inc = ptr_q + CW'(1);
	assign ptr_dec = ptr_q - CW'(1);
	assign cnt_dec = count_q - CW'(1);
	assign cur_ext = CW'(cur_q);

	always_comb begin
		st.in_reorder = do_reorder;
		st.in_kind    = kind;
		st.full       = full;
		st.empty      = empty;
		st.short_list = (count_q <= CW'(2));
		st.ins_more   = (ptr_q > cur_ext);
		st.rem_more   = (ptr_inc < count_q);
		st.k_more     = (ptr_q < count_q);
	end

	// status and start pointer taken at accept
	always_comb begin
		acc_status = clb_pkg::STAT_OK;
		acc_ptr    = '0;
		if (!do_reorder) begin
			unique case (kind)
				clb_pkg::KIND_INSERT: begin
					acc_ptr = count_q;
					if (full) acc_status = clb_pkg::STAT_FULL;
				end
				clb_pkg::KIND_APPEND: begin
					if (full) acc_status = clb_pkg::STAT_FULL;
				end
				clb_pkg::KIND_REMOVE: begin
					acc_ptr = cur_ext;
					if (empty) acc_status = clb_pkg::STAT_EMPTY;
				end
				clb_pkg::KIND_MOVE: begin
					if ({26'd0, target_position} >= 32'(count_q)) begin
						acc_status = clb_pkg::STAT_BADPOS;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		raddr = cur_q;
		waddr = IW'(ptr_q);
		saddr = IW'(ptr_q);
		we    = 1'b0;
		swe   = 1'b0;
		wdata = rd_q;
		unique case (cmd)
			clb_pkg::CMD_INS_RD:  raddr = IW'(ptr_dec);
			clb_pkg::CMD_REM_NXT: raddr = IW'(ptr_inc);
			clb_pkg::CMD_RO_RD:   raddr = ptr_q[0] ? hi_q : lo_q;
			clb_pkg::CMD_INS_WR,
			clb_pkg::CMD_REM_WR:  we = 1'b1;
			clb_pkg::CMD_INS_PUT: begin
				we    = 1'b1;
				waddr = cur_q;
				wdata = val_q;
			end
			clb_pkg::CMD_APP: begin
				we    = 1'b1;
				waddr = IW'(count_q);
				wdata = val_q;
			end
			clb_pkg::CMD_RO_WR:   swe = 1'b1;
			clb_pkg::CMD_CP_WR: begin
				we    = 1'b1;
				wdata = srd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		rd_q <= store_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			scratch_mem[saddr] <= rd_q;
		end
		srd_q <= scratch_mem[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cur_q   <= '0;
		end else begin
			unique case (cmd)
				clb_pkg::CMD_ACCEPT: begin
					if (!do_reorder) begin
						unique case (kind)
							clb_pkg::KIND_START: cur_q <= '0;
							clb_pkg::KIND_END:   cur_q <= empty ? '0 : IW'(cnt_dec);
							clb_pkg::KIND_PREV: begin
								if (cur_q != '0) cur_q <= cur_q - IW'(1);
							end
							clb_pkg::KIND_NEXT: begin
								if (!empty && (cur_ext < cnt_dec)) cur_q <= cur_q + IW'(1);
							end
							clb_pkg::KIND_MOVE: begin
								if ({26'd0, target_position} < 32'(count_q)) begin
									cur_q <= IW'(target_position);
								end
							end
							default: ;
						endcase
					end
				end
				clb_pkg::CMD_INS_PUT,
				clb_pkg::CMD_APP: count_q <= count_q + CW'(1);
				clb_pkg::CMD_REM_END: begin
					count_q <= cnt_dec;
					if ((cnt_dec == cur_ext) && (cur_q != '0)) cur_q <= cur_q - IW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			clb_pkg::CMD_ACCEPT: begin
				val_q     <= new_value;
				removed_q <= '0;
				status_q  <= acc_status;
				lo_q      <= '0;
				hi_q      <= IW'(cnt_dec);
				ptr_q     <= acc_ptr;
			end
			clb_pkg::CMD_INS_WR:  ptr_q <= ptr_dec;
			clb_pkg::CMD_REM_CAP: removed_q <= rd_q;
			clb_pkg::CMD_REM_WR:  ptr_q <= ptr_inc;
			clb_pkg::CMD_RO_WR: begin
				ptr_q <= ptr_inc;
				if (ptr_q[0]) begin
					hi_q <= hi_q - IW'(1);
				end else begin
					lo_q <= lo_q + IW'(1);
				end
			end
			clb_pkg::CMD_RO_RD: ;
			clb_pkg::CMD_RO_END:  ptr_q <= '0;
			clb_pkg::CMD_CP_WR:   ptr_q <= ptr_inc;
			clb_pkg::CMD_FIN_OUT: begin
				status          <= status_q;
				removed_value   <= $signed(removed_q);
				cursor_value    <= empty ? 32'sd0 : $signed(rd_q);
				cursor_valid    <= !empty;
				list_length     <= 7'(count_q);
				cursor_position <= 6'(cur_q);
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/cursor_list_buffer_top.sv =====
// top level of the cursor list buffer
// One item at a time: the block takes a beat only when idle and answers with one result beat.
// Insert and remove shift the entries from the cursor to the end of the list, and reorder works
// on every entry unless the list holds two or less. The work is set by the single-port entry
// memory with its registered read, which moves one entry at a time, and reorder goes through a
// scratch memory and back. A result that waits on the output holds the block in its last step
// until it is taken.
module cursor_list_buffer_top #(
	parameter int CAPACITY = clb_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic               do_reorder,
	input  logic signed [31:0] new_value,
	input  logic [5:0]         target_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic signed [31:0] cursor_value,
	output logic               cursor_valid,
	output logic [6:0]         list_length,
	output logic [5:0]         cursor_position
);

	clb_pkg::cmd_t       cmd;
	clb_pkg::dp_status_t st;

	clb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	clb_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.kind            (kind),
		.do_reorder      (do_reorder),
		.new_value       (new_value),
		.target_position (target_position),
		.status          (status),
		.removed_value   (removed_value),
		.cursor_value    (cursor_value),
		.cursor_valid    (cursor_valid),
		.list_length     (list_length),
		.cursor_position (cursor_position)
	);

endmodule

// ===== tb/testbench.sv =====
// testbench for the cursor list buffer: directed and random beats checked against a list model
module testbench;
	import clb_pkg::*;

	localparam int CAP = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic signed [31:0] cursor_value;
		logic               cursor_valid;
		logic [6:0]         list_length;
		logic [5:0]         cursor_position;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         kind;
	logic               do_reorder;
	logic signed [31:0] new_value;
	logic [5:0]         target_position;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic signed [31:0] cursor_value;
	logic               cursor_valid;
	logic [6:0]         list_length;
	logic [5:0]         cursor_position;

	logic signed [31:0] model_list [CAP];
	int                 model_len;
	int                 model_cur;
	list_result_t       result_q [$];
	int                 errors;
	int                 beats_sent;
	int                 beats_checked;
	int                 cycles;
	int                 idle_mode;
	int                 hold_cycles;

	cursor_list_buffer_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .do_reorder(do_reorder), .new_value(new_value),
		.target_position(target_position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .removed_value(removed_value), .cursor_value(cursor_value),
		.cursor_valid(cursor_valid), .list_length(list_length),
		.cursor_position(cursor_position)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic list_result_t apply_op(logic [2:0] k, logic ro, logic signed [31:0] v,
			logic [5:0] tgt);
		list_result_t r;
		logic signed [31:0] tmp [CAP];
		int lo;
		int hi;
		int j;
		r.status = STAT_OK;
		r.removed_value = '0;
		r.cursor_value = '0;
		if (ro) begin
			if (model_len > 2) begin
				lo = 0;
				hi = model_len - 1;
				j = 0;
				while (j < model_len) begin
					tmp[j] = model_list[lo];
					j = j + 1;
					lo = lo + 1;
					if (j < model_len) begin
						tmp[j] = model_list[hi];
						j = j + 1;
						hi = hi - 1;
					end
				end
				for (int i = 0; i < model_len; i++)
					model_list[i] = tmp[i];
			end
		end else begin
			case (k)
				KIND_INSERT: begin
					if (model_len >= CAP) begin
						r.status = STAT_FULL;
					end else begin
						if (model_len == 0)
							model_cur = 0;
						for (int i = model_len; i > model_cur; i--)
							model_list[i] = model_list[i-1];
						model_list[model_cur] = v;
						model_len++;
					end
				end
				KIND_APPEND: begin
					if (model_len >= CAP) begin
						r.status = STAT_FULL;
					end else begin
						model_list[model_len] = v;
						model_len++;
					end
				end
				KIND_REMOVE: begin
					if (model_len == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						r.removed_value = model_list[model_cur];
						for (int i = model_cur; i + 1 < model_len; i++)
							model_list[i] = model_list[i+1];
						model_len--;
						if (model_len == model_cur && model_cur > 0)
							model_cur--;
					end
				end
				KIND_START: model_cur = 0;
				KIND_END: model_cur = model_len ? model_len - 1 : 0;
				KIND_PREV: if (model_cur > 0) model_cur--;
				KIND_NEXT: if (model_len > 0 && model_cur < model_len - 1) model_cur++;
				default: begin
					if (tgt >= model_len)
						r.status = STAT_BADPOS;
					else
						model_cur = tgt;
				end
			endcase
		end
		if (model_len == 0)
			model_cur = 0;
		if (model_len > 0)
			r.cursor_value = model_list[model_cur];
		r.cursor_valid = model_len > 0;
		r.list_length = 7'(model_len);
		r.cursor_position = 6'(model_cur);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at result %0d: %s got %0h want %0h", beats_checked, what, got, want);
		errors++;
	endtask

	function automatic bit sender_idles();
		case (idle_mode)
			1: return $urandom_range(0, 99) < 72;
			3: return $urandom_range(0, 99) < 8;
			default: return 1'b0;
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_op(logic [2:0] k, logic ro, logic signed [31:0] v, logic [5:0] tgt);
		while (sender_idles()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		do_reorder = ro;
		new_value = v;
		target_position = tgt;
		do @(posedge clk); while (!in_ready);
		result_q.push_back(apply_op(k, ro, v, tgt));
		beats_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (result_q.size() != 0)
			@(negedge clk);
	endtask

	// receiver side: random stalls plus long hold-offs
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			case (idle_mode)
				2: out_ready <= $urandom_range(0, 99) >= 72;
				3: out_ready <= $urandom_range(0, 99) >= 8;
				default: out_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		list_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report("unexpected beat", 0, 0);
			end else begin
				w = result_q.pop_front();
				if (status !== w.status) report("status", status, w.status);
				if (removed_value !== w.removed_value)
					report("removed_value", removed_value, w.removed_value);
				if (cursor_value !== w.cursor_value)
					report("cursor_value", cursor_value, w.cursor_value);
				if (cursor_valid !== w.cursor_valid)
					report("cursor_valid", cursor_valid, w.cursor_valid);
				if (list_length !== w.list_length)
					report("list_length", list_length, w.list_length);
				if (cursor_position !== w.cursor_position)
					report("cursor_position", cursor_position, w.cursor_position);
			end
			beats_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_empty_list();
		send_op(KIND_REMOVE, 1'b0, 0, 0);
		send_op(KIND_END, 1'b0, 0, 0);
		send_op(KIND_PREV, 1'b0, 0, 0);
		send_op(KIND_NEXT, 1'b0, 0, 0);
		send_op(KIND_MOVE, 1'b0, 0, 0);
		send_op(KIND_START, 1'b1, 0, 0);
	endtask

	task automatic test_basic_ops();
		send_op(KIND_INSERT, 1'b0, 32'sh7fffffff, 0);
		send_op(KIND_APPEND, 1'b0, 32'sh80000000, 0);
		send_op(KIND_START, 1'b1, 0, 0);
		send_op(KIND_INSERT, 1'b0, -1, 0);
		send_op(KIND_APPEND, 1'b0, 0, 6'h3f);
		send_op(KIND_END, 1'b0, 0, 0);
		send_op(KIND_NEXT, 1'b0, 0, 0);
		send_op(KIND_START, 1'b0, 0, 0);
		send_op(KIND_PREV, 1'b0, 0, 0);
		send_op(KIND_MOVE, 1'b0, 0, 2);
		send_op(KIND_MOVE, 1'b0, 0, 4);
		send_op(KIND_MOVE, 1'b0, 0, 6'h3f);
		send_op(KIND_START, 1'b1, 0, 0);
		send_op(KIND_END, 1'b0, 0, 0);
		// removing the tail pulls the cursor back
		send_op(KIND_REMOVE, 1'b0, 0, 0);
		send_op(KIND_REMOVE, 1'b0, 0, 0);
		send_op(KIND_REMOVE, 1'b0, 0, 0);
		send_op(KIND_REMOVE, 1'b0, 0, 0);
		send_op(KIND_REMOVE, 1'b0, 0, 0);
	endtask

	task automatic test_full_list();
		while (model_len < CAP)
			send_op(KIND_APPEND, 1'b0, $urandom, 0);
		send_op(KIND_INSERT, 1'b0, 1, 0);
		send_op(KIND_APPEND, 1'b0, 2, 0);
		send_op(KIND_MOVE, 1'b0, 0, 6'h3f);
		send_op(KIND_START, 1'b1, 0, 0);
		send_op(KIND_NEXT, 1'b0, 0, 0);
		while (model_len > 0)
			send_op(KIND_REMOVE, 1'b0, 0, 0);
	endtask

	task automatic send_random_op();
		int r;
		logic [2:0] k;
		logic [5:0] tgt;
		r = $urandom_range(0, 99);
		tgt = $urandom_range(0, 1) ? 6'($urandom_range(0, model_len)) : 6'($urandom);
		if (r < 8)
			send_op(3'($urandom), 1'b1, $urandom, tgt);
		else if (r < 40)
			send_op(KIND_INSERT, 1'b0, $urandom, tgt);
		else if (r < 52)
			send_op(KIND_APPEND, 1'b0, $urandom, tgt);
		else if (r < 75)
			send_op(KIND_REMOVE, 1'b0, $urandom, tgt);
		else begin
			k = 3'($urandom_range(KIND_START, KIND_MOVE));
			send_op(k, 1'b0, $urandom, tgt);
		end
	endtask

	task automatic test_random(int mode, int count);
		idle_mode = mode;
		repeat (count)
			send_random_op();
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_mode = 0;
		hold_cycles = 400;
		repeat (20)
			send_random_op();
		wait_drained();
		repeat (10)
			send_random_op();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		do_reorder = 1'b0;
		new_value = '0;
		target_position = '0;
		out_ready = 1'b0;
		idle_mode = 0;
		hold_cycles = 0;
		errors = 0;
		beats_sent = 0;
		beats_checked = 0;
		cycles = 0;
		model_len = 0;
		model_cur = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random(0, 65);
		test_random(1, 65);
		test_random(2, 65);
		test_random(3, 65);
		test_backpressure();

		wait_drained();
		repeat (600) @(negedge clk);
		$display("sent %0d operations, checked %0d results over %0d cycles",
			beats_sent, beats_checked, cycles);
		$display("covered empty and full lists, reorder, all cursor moves and output stalls");
		if (errors == 0 && result_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, result_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/clb_pkg.sv
rtl/clb_ctrl.sv
rtl/clb_dp.sv
rtl/cursor_list_buffer_top.sv
tb/testbench.sv
